// File: rtl/vn_pkg.sv
// shared types and constants for the vector normalizer
package vn_pkg;

    localparam int ELEM_W = 32;
    localparam int MAG_W  = 36;
    localparam int ROOT_W = 32;
    localparam int SUM_W  = 64;
    localparam int Q_W    = 31;
    localparam int NUM_W  = 62;
    localparam logic [Q_W-1:0] ONE_Q30 = Q_W'(1) << 30;

    typedef enum logic [5:0] {
        ST_LOAD   = 6'b000001,
        ST_DRAIN  = 6'b000010,
        ST_ROOT   = 6'b000100,
        ST_READ   = 6'b001000,
        ST_DSTART = 6'b010000,
        ST_DIV    = 6'b100000
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

    function automatic logic [ELEM_W-1:0] abs_of(input logic [ELEM_W-1:0] e);
        abs_of = e[ELEM_W-1] ? (~e + ELEM_W'(1)) : e;
    endfunction

endpackage

// File: rtl/vn_store.sv
// element store, one write port and one registered read port
module vn_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [vn_pkg::ELEM_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [vn_pkg::ELEM_W-1:0] rd_data
);
    import vn_pkg::*;

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: rtl/vn_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
module vn_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [vn_pkg::SUM_W-1:0]  radicand,
    output logic                      done,
    output logic [vn_pkg::ROOT_W-1:0] root
);
    import vn_pkg::*;

    logic [SUM_W-1:0]  x_reg;
    logic [ROOT_W+2:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;

    assign rem_sh = {rem_reg[ROOT_W:0], x_reg[SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                x_reg <= {x_reg[SUM_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// File: rtl/vn_div.sv
// restoring divider for |element| * 2^30 / magnitude, rounded and clamped to 1.0
module vn_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [vn_pkg::ELEM_W-1:0] abs_elem,
    input  logic [vn_pkg::ROOT_W-1:0] mag,
    output logic                      done,
    output logic [vn_pkg::Q_W-1:0]    quot
);
    import vn_pkg::*;

    logic [NUM_W-1:0] num;
    logic             sat;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dvs_reg;
    logic [Q_W-1:0]   q_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    assign num = {abs_elem, 30'b0} + NUM_W'(mag >> 1);
    assign sat = {1'b0, num} >= {mag, 31'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg <= num;
                dvs_reg <= {mag, 30'b0};
                cnt_reg <= '0;
                if (mag == '0) begin
                    q_reg    <= '0;
                    done_reg <= 1'b1;
                end else if (sat) begin
                    q_reg    <= ONE_Q30;
                    done_reg <= 1'b1;
                end else begin
                    q_reg    <= '0;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (rem_reg >= dvs_reg) begin
                    rem_reg <= rem_reg - dvs_reg;
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                end
                dvs_reg <= dvs_reg >> 1;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd30) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = (q_reg > ONE_Q30) ? ONE_Q30 : q_reg;
endmodule

// File: rtl/vector_normalize_top.sv
// top level of the streaming l2 vector normalizer
// Elements load at one per cycle while s_tready is high (only in the load
// state) into an on-chip store while their squares pass a two-stage multiply
// and saturating accumulate. After the element marked tlast, the pipeline
// drains, the bit-serial square root is started and runs, then each stored
// element is read and handed to the divider, divided by a 31-step restoring
// divider (whose steps are skipped when the magnitude is zero or the quotient
// saturates) and placed in the output register once that register is free,
// so a receiver that holds off a waiting result stalls the next element.
// Elements past MAX_LEN are dropped and flagged in tuser on every result.
module vector_normalize_top #(
    parameter int MAX_LEN = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // element
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // unit_element, magnitude, zero pad
    output logic        m_tlast,   // final_res
    output logic        m_tuser    // overflowed
);
    import vn_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              dropped_reg;
    logic [ELEM_W-1:0] a_reg;
    logic              v1_reg;
    logic [SUM_W-1:0]  sq_reg;
    logic              v2_reg;
    logic [ROOT_W-1:0] mag_reg;
    logic              neg_reg;
    logic              div_pend_reg;
    logic [ELEM_W-1:0] rd_data;
    logic [SUM_W:0]    sum_wide;
    logic              accept;
    logic              room;
    logic              out_free;
    logic              is_final;
    unit_ctl_t         sqrt_ctl;
    unit_ctl_t         div_ctl;
    logic [ROOT_W-1:0] root;
    logic [Q_W-1:0]    quot;

    logic              m_tvalid_reg;
    logic [ELEM_W-1:0] unit_reg;
    logic [MAG_W-1:0]  mag_out_reg;
    logic              final_reg;
    logic              ovf_reg;

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign room     = (count_reg != CNT_W'(MAX_LEN));
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_final = ((idx_reg + CNT_W'(1)) == count_reg);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, sq_reg};

    assign sqrt_ctl.start = (state_reg == ST_DRAIN) && !v1_reg && !v2_reg;
    assign div_ctl.start  = (state_reg == ST_DSTART);

    vn_store #(.DEPTH(MAX_LEN), .ADDR_W(IDX_W)) u_store (
        .aclk    (aclk),
        .wr_en   (accept && room),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    vn_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_ctl.start),
        .radicand (sum_reg),
        .done     (sqrt_ctl.done),
        .root     (root)
    );

    vn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_ctl.start),
        .abs_elem (abs_of(rd_data)),
        .mag      (mag_reg),
        .done     (div_ctl.done),
        .quot     (quot)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:   if (accept && s_tlast) state_next = ST_DRAIN;
            ST_DRAIN:  if (sqrt_ctl.start) state_next = ST_ROOT;
            ST_ROOT:   if (sqrt_ctl.done) state_next = ST_READ;
            ST_READ:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV: begin
                if (div_pend_reg && out_free) begin
                    state_next = is_final ? ST_LOAD : ST_READ;
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            idx_reg      <= '0;
            sum_reg      <= '0;
            dropped_reg  <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            div_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= accept && room;
            v2_reg    <= v1_reg;
            if (accept) begin
                if (room) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (v2_reg) begin
                sum_reg <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
            end
            if (state_reg == ST_ROOT && sqrt_ctl.done) begin
                idx_reg <= '0;
            end
            if (div_ctl.done) begin
                div_pend_reg <= 1'b1;
            end
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == ST_DIV && div_pend_reg && out_free) begin
                div_pend_reg <= 1'b0;
                m_tvalid_reg <= 1'b1;
                idx_reg      <= idx_reg + CNT_W'(1);
                if (is_final) begin
                    count_reg   <= '0;
                    sum_reg     <= '0;
                    dropped_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg <= abs_of(s_tdata);
        end
        if (v1_reg) begin
            sq_reg <= a_reg * a_reg;
        end
        if (state_reg == ST_ROOT && sqrt_ctl.done) begin
            mag_reg <= root;
        end
        if (div_ctl.start) begin
            neg_reg <= rd_data[ELEM_W-1];
        end
        if (state_reg == ST_DIV && div_pend_reg && out_free) begin
            unit_reg    <= neg_reg ? (ELEM_W'(0) - ELEM_W'(quot)) : ELEM_W'(quot);
            mag_out_reg <= MAG_W'(mag_reg);
            final_reg   <= is_final;
            ovf_reg     <= dropped_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, mag_out_reg, unit_reg};
    assign m_tlast  = final_reg;
    assign m_tuser  = ovf_reg;

    a_root_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_ctl.start |-> !v1_reg && !v2_reg && !accept)
        else $error("square root started with squares still in flight");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_READ) |-> idx_reg < count_reg)
        else $error("read index past stored count");

    a_mag_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && $past(state_reg) == ST_DIV) |-> $stable(mag_reg))
        else $error("magnitude changed during emit");
endmodule

// File: tb/testbench.sv
// self-checking testbench for the streaming l2 vector normalizer
`timescale 1ns / 1ps

module testbench;
    import vn_pkg::*;

    localparam int VEC_MAX = 64;
    localparam logic [31:0] ONE_Q30_W = 32'h4000_0000;

    typedef struct packed {
        logic [31:0] unit_elem;
        logic [35:0] mag;
        logic        fin;
        logic        ovf;
    } unit_result_t;

    typedef struct {
        logic [31:0] elem;
        logic        last;
        logic        has_exp;
        logic [31:0] exp_unit;
        logic [35:0] exp_mag;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    vector_normalize_top #(.MAX_LEN(VEC_MAX)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    logic signed [31:0] vec_store[VEC_MAX];
    int unsigned        vec_len;
    logic [63:0]        sq_sum;
    logic               drop_seen;
    unit_result_t       unit_q[$];
    int                 n_err, n_results, n_vectors, n_items;
    bit                 hold_long;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem, res, bitv;
        rem = x;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // fold one element into the vector state, queue unit results on the last one
    task automatic normalize_accept(input logic [31:0] elem, input logic last);
        logic [63:0] a, sq, s, mag, q;
        logic [31:0] u;
        if (vec_len < VEC_MAX) begin
            a = elem[31] ? 64'(-$signed({32'hffff_ffff, elem})) : 64'(elem);
            sq = a * a;
            s = sq_sum + sq;
            if (s < sq) s = '1;
            sq_sum = s;
            vec_store[vec_len] = elem;
            vec_len++;
        end else begin
            drop_seen = 1'b1;
        end
        if (!last) return;
        mag = (sq_sum == 0) ? 64'd0 : isqrt64(sq_sum);
        for (int k = 0; k < vec_len; k++) begin
            a = vec_store[k][31] ? 64'(-$signed({32'hffff_ffff, vec_store[k]}))
                                 : 64'(vec_store[k]);
            q = 0;
            if (mag != 0) begin
                q = ((a << 30) + (mag >> 1)) / mag;
                if (q > 64'(ONE_Q30_W)) q = 64'(ONE_Q30_W);
            end
            u = vec_store[k][31] ? (32'd0 - q[31:0]) : q[31:0];
            unit_q.push_back('{u, mag[35:0], (k + 1 == vec_len), drop_seen});
        end
        vec_len = 0;
        sq_sum = 0;
        drop_seen = 1'b0;
        n_vectors++;
    endtask

    task automatic send_elem(input logic [31:0] elem, input logic last);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= elem;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        normalize_accept(elem, last);
        n_items++;
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (unit_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_elem(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'd0;
        endcase
    endfunction

    // output side: random stalls, one long hold-off on request, checks
    initial begin
        unit_result_t got, want;
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_long = 0;
            end
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 1);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[31:0], m_tdata[67:32], m_tlast, m_tuser};
                n_results++;
                if (unit_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result %h", got);
                end else begin
                    want = unit_q.pop_front();
                    if (got !== want || m_tdata[71:68] !== 4'd0) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp unit %h mag %h last %b ovf %b, got %h %h %b %b",
                                     want.unit_elem, want.mag, want.fin, want.ovf,
                                     got.unit_elem, got.mag, got.fin, got.ovf);
                    end
                end
            end
        end
    end

    stim_row_t dir_rows[$];

    initial begin
        int len, mode;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        aresetn  = 1'b0;
        n_err = 0; n_results = 0; n_vectors = 0; n_items = 0;
        hold_long = 0;
        vec_len = 0; sq_sum = 0; drop_seen = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: zero vector, single elements at extremes, mixed signs
        dir_rows.push_back('{32'h0000_0000, 1'b1, 1'b1, 32'h0, 36'h0});
        dir_rows.push_back('{32'h0001_0000, 1'b1, 1'b1, ONE_Q30_W, 36'h1_0000});
        dir_rows.push_back('{32'h7fff_ffff, 1'b1, 1'b1, ONE_Q30_W, 36'h7fff_ffff});
        dir_rows.push_back('{32'h8000_0000, 1'b1, 1'b1, 32'hc000_0000, 36'h8000_0000});
        dir_rows.push_back('{32'hffff_ffff, 1'b1, 1'b1, 32'hc000_0000, 36'h1});
        dir_rows.push_back('{32'h0003_0000, 1'b0, 1'b0, 0, 0});
        dir_rows.push_back('{32'hfffc_0000, 1'b1, 1'b0, 0, 0});
        dir_rows.push_back('{32'h0000_0000, 1'b0, 1'b0, 0, 0});
        dir_rows.push_back('{32'h0000_0000, 1'b1, 1'b0, 0, 0});
        dir_rows.push_back('{32'h8000_0000, 1'b0, 1'b0, 0, 0});
        dir_rows.push_back('{32'h8000_0000, 1'b0, 1'b0, 0, 0});
        dir_rows.push_back('{32'h7fff_ffff, 1'b0, 1'b0, 0, 0});
        dir_rows.push_back('{32'h8000_0000, 1'b1, 1'b0, 0, 0});
        dir_rows.push_back('{32'h5555_aaaa, 1'b0, 1'b0, 0, 0});
        dir_rows.push_back('{32'haaaa_5555, 1'b1, 1'b0, 0, 0});
        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_exp) begin
                send_elem(dir_rows[i].elem, dir_rows[i].last);
                if (unit_q[$].unit_elem !== dir_rows[i].exp_unit
                        || unit_q[$].mag !== dir_rows[i].exp_mag) begin
                    n_err++;
                    $display("predictor disagrees with table row %0d", i);
                end
            end else begin
                send_elem(dir_rows[i].elem, dir_rows[i].last);
            end
        end

        // overflow: more than the store holds, a dropped element ends the run
        for (int i = 0; i < VEC_MAX + 3; i++)
            send_elem(rand_elem(1), i == VEC_MAX + 2);
        wait_drained();

        // long receiver hold-off while elements keep coming
        hold_long = 1;
        for (int i = 0; i < 40; i++) send_elem(rand_elem(0), i % 8 == 7);
        wait_drained();

        // random vectors, mostly short
        while (n_items < 360) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, VEC_MAX + 4)
                                               : $urandom_range(1, 6);
            mode = $urandom_range(0, 5);
            for (int i = 0; i < len; i++)
                send_elem((mode == 5) ? rand_elem($urandom_range(0, 3)) : rand_elem(mode % 4),
                          i == len - 1);
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge aclk);
        $display("%0d elements in %0d vectors, %0d unit results checked", n_items, n_vectors,
                 n_results);
        $display("covered zero, extreme, saturating and overflowing vectors under stalls");
        if (n_err == 0 && unit_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results outstanding", n_err, unit_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: vector_normalize_top.f
rtl/vn_pkg.sv
rtl/vn_store.sv
rtl/vn_sqrt.sv
rtl/vn_div.sv
rtl/vector_normalize_top.sv
tb/testbench.sv
